FILE: hdl/alf_pkg.sv
package alf_pkg;

  // Default parameter values
  localparam int unsigned DEF_MAX_LEN     = 32;
  localparam int unsigned DEF_BLOCK_PAIRS = 16;
  localparam int unsigned DEF_FRAC_BITS   = 16;

  // Field widths
  localparam int unsigned SMP_W   = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned RATIO_W = 21;
  localparam int unsigned LEN_W   = 6;

  // Fit arithmetic widths
  localparam int unsigned N_W   = 5;    // pairs in a block, up to 16
  localparam int unsigned SUM_W = 37;   // sum of up to 16 samples
  localparam int unsigned SQ_W  = 69;   // sum of up to 16 sample products
  localparam int unsigned MC_W  = 74;   // multiplicand, also N and D
  localparam int unsigned PR_W  = 111;  // serial product
  localparam int unsigned Y_W   = 76;   // divisor
  localparam int unsigned QT_W  = 42;   // quotient magnitude
  localparam int unsigned DV_W  = 120;  // divider remainder
  localparam int unsigned CNT_W = 6;    // step counter of the serial units

  typedef enum logic [KIND_W-1:0] {
    KIND_PARAM    = 2'd0,
    KIND_RESIDUAL = 2'd1,
    KIND_BASE     = 2'd2
  } kind_e;

  typedef struct packed {
    logic [N_W-1:0]           n;
    logic signed [SUM_W-1:0]  sa;
    logic signed [SUM_W-1:0]  sb;
    logic signed [SQ_W-1:0]   saa;
    logic signed [SQ_W-1:0]   sab;
  } fit_req_t;

  typedef struct packed {
    logic signed [RATIO_W-1:0] ratio;
    logic [SMP_W-1:0]          offset;
  } fit_rsp_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_PADRD, ST_PADWR, ST_LVL, ST_BLK, ST_SUMRD, ST_SUMMUL, ST_SUMACC,
    ST_FIT, ST_FITW, ST_PARAM, ST_RESRD, ST_RESMUL, ST_RESOUT, ST_BASERD, ST_BASE
  } top_state_e;

  typedef enum logic [3:0] {
    FS_IDLE, FS_MLOAD, FS_MRUN, FS_MFIN, FS_MSTORE, FS_DEC, FS_DLOAD, FS_DRUN, FS_DFIN
  } fit_state_e;

  // Products taken in order by the serial multiplier
  typedef enum logic [2:0] {
    OP_NSAB, OP_SASB, OP_NSAA, OP_SASA, OP_SBD, OP_NSA, OP_ND
  } fit_op_e;

endpackage

FILE: hdl/adaptive_lifting_forward_core.sv
// Channel   Direction  Ports                                   Transaction
// ------    ---------  --------------------------------------  --------------------------------
// sample    in         start, busy, sample_i, final_sample_i   start high while busy low
// result    out        result_strobe_o, kind_o .. last_result_o one cycle, strobe high
//
// Loading accepts one sample per cycle; busy stays low between samples.
// The final sample starts the run: the last kept sample is repeated up to the
// padded length, then each level fits each block with the bit-serial multiplier
// and divider in the block fit unit (a shorter path when the slope is zeroed or
// clamped) and emits its parameters and residuals. The base item comes last.
// Reset clears the sample count, the overflow flag and the sequencer; the
// sample memory is not cleared. The receiver cannot stall results.
module adaptive_lifting_forward_core #(
  parameter int unsigned MAX_LEN     = alf_pkg::DEF_MAX_LEN,
  parameter int unsigned BLOCK_PAIRS = alf_pkg::DEF_BLOCK_PAIRS,
  parameter int unsigned FRAC_BITS   = alf_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [alf_pkg::SMP_W-1:0]   sample_i,
  input  logic                               final_sample_i,
  output logic                               result_strobe_o,
  output logic [alf_pkg::KIND_W-1:0]         kind_o,
  output logic [alf_pkg::LEVEL_W-1:0]        level_o,
  output logic [alf_pkg::POS_W-1:0]          position_o,
  output logic signed [alf_pkg::SMP_W-1:0]   value_o,
  output logic signed [alf_pkg::RATIO_W-1:0] ratio_o,
  output logic signed [alf_pkg::SMP_W-1:0]   offset_o,
  output logic [alf_pkg::LEN_W-1:0]          length_o,
  output logic                               overflowed_o,
  output logic                               last_result_o
);

  localparam int unsigned AW      = $clog2(MAX_LEN);
  localparam int unsigned DEPTH   = 1 << AW;         // padded length fits
  localparam int unsigned CW      = $clog2(MAX_LEN + 1);
  localparam int unsigned SMP_W   = alf_pkg::SMP_W;
  localparam int unsigned SUM_W   = alf_pkg::SUM_W;
  localparam int unsigned SQ_W    = alf_pkg::SQ_W;
  localparam int unsigned N_W     = alf_pkg::N_W;
  localparam int unsigned LEVEL_W = alf_pkg::LEVEL_W;
  localparam int unsigned POS_W   = alf_pkg::POS_W;
  localparam int unsigned RATIO_W = alf_pkg::RATIO_W;
  localparam int unsigned PM_W    = SMP_W + RATIO_W;

  alf_pkg::top_state_e state_q, state_d;

  logic [CW-1:0] cnt_q;
  logic          ovf_q;

  // Sample memory: two read ports, one write port. Each level writes its low
  // band in place; pair i reads entries 2i and 2i+1 and writes entry i, which
  // no later pair of the level reads.
  logic [SMP_W-1:0] mem [DEPTH];
  logic [SMP_W-1:0] rd0_q, rd1_q;
  logic [AW-1:0]    ra0, ra1, wa;
  logic [SMP_W-1:0] wd;
  logic             re, we;

  // sequencer position
  logic [AW:0]          plen_q, ptr_q, e_q, plen_c;
  logic [AW-1:0]        half_q, s_q, i_q;
  logic [LEVEL_W-1:0]   lvl_q;
  logic [POS_W-1:0]     blk_q;
  logic [N_W-1:0]       n_q;
  logic [N_W-1:0]       n_c;
  logic [AW-1:0]        rem_c;
  logic [AW:0]          ip1;

  // block sums
  logic signed [SUM_W-1:0]     sa_q, sb_q;
  logic signed [SQ_W-1:0]      saa_q, sab_q;
  logic signed [2*SMP_W-1:0]   aa_q, ab_q;
  alf_pkg::fit_req_t fit_req;
  alf_pkg::fit_rsp_t fit_rsp;
  logic fit_start, fit_done;

  // residual path
  logic [PM_W-1:0]  prod_q;
  logic             pneg_q;
  logic [SMP_W-1:0] amag;
  logic [RATIO_W-1:0] rmag;
  logic [PM_W-1:0]  qrnd;
  logic [SMP_W-1:0] pm, dres, low;

  // result item
  logic                       emit;
  alf_pkg::kind_e             e_kind;
  logic [POS_W-1:0]           e_pos;
  logic [SMP_W-1:0]           e_value;
  logic [RATIO_W-1:0]         e_ratio;
  logic [SMP_W-1:0]           e_offset;
  logic                       e_last;
  logic                       strobe_q;
  alf_pkg::kind_e             kind_q;
  logic [LEVEL_W-1:0]         level_q;
  logic [POS_W-1:0]           pos_q;
  logic [SMP_W-1:0]           value_q, offset_q;
  logic [RATIO_W-1:0]         ratio_q;
  logic [alf_pkg::LEN_W-1:0]  length_q;
  logic                       ovfo_q, last_q;

  logic accept;

  assign busy   = (state_q != alf_pkg::ST_LOAD);
  assign accept = start && !busy;

  // smallest power of two that holds the kept samples
  always_comb begin
    plen_c = '0;
    for (int k = AW; k >= 0; k--) begin
      if (((AW+1)'(1) << k) >= (AW+1)'(cnt_q)) plen_c = (AW+1)'(1) << k;
    end
  end

  assign rem_c = half_q - s_q;
  assign n_c   = (int'(rem_c) > int'(BLOCK_PAIRS)) ? N_W'(BLOCK_PAIRS) : N_W'(rem_c);
  assign ip1   = (AW+1)'(i_q) + (AW+1)'(1);

  // residual: d = b - (round(a*ratio) + offset), low = a + floor(d/2)
  always_comb begin
    amag = rd0_q[SMP_W-1] ? SMP_W'(-rd0_q) : rd0_q;
    rmag = fit_rsp.ratio[RATIO_W-1] ? RATIO_W'(-fit_rsp.ratio) : RATIO_W'(fit_rsp.ratio);
    qrnd = (prod_q + (PM_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    pm   = pneg_q ? SMP_W'(-qrnd[SMP_W-1:0]) : qrnd[SMP_W-1:0];
    dres = rd1_q - pm - fit_rsp.offset;
    low  = rd0_q + {dres[SMP_W-1], dres[SMP_W-1:1]};
  end

  assign fit_req.n   = n_q;
  assign fit_req.sa  = sa_q;
  assign fit_req.sb  = sb_q;
  assign fit_req.saa = saa_q;
  assign fit_req.sab = sab_q;

  alf_fit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fit_start),
    .req_i   (fit_req),
    .done_o  (fit_done),
    .rsp_o   (fit_rsp)
  );

  // next state, memory ports and result item
  always_comb begin
    state_d   = state_q;
    re        = 1'b0;
    ra0       = '0;
    ra1       = '0;
    we        = 1'b0;
    wa        = '0;
    wd        = '0;
    fit_start = 1'b0;
    emit      = 1'b0;
    e_kind    = alf_pkg::KIND_PARAM;
    e_pos     = '0;
    e_value   = '0;
    e_ratio   = '0;
    e_offset  = '0;
    e_last    = 1'b0;
    unique case (state_q)
      alf_pkg::ST_LOAD: begin
        if (accept) begin
          if (int'(cnt_q) < int'(MAX_LEN)) begin
            we = 1'b1;
            wa = AW'(cnt_q);
            wd = sample_i;
          end
          if (final_sample_i) state_d = alf_pkg::ST_PADRD;
        end
      end
      alf_pkg::ST_PADRD: begin
        re      = 1'b1;
        ra0     = AW'(cnt_q - CW'(1));
        state_d = alf_pkg::ST_PADWR;
      end
      alf_pkg::ST_PADWR: begin
        // repeat the last kept sample up to the padded length
        if (ptr_q < plen_q) begin
          we = 1'b1;
          wa = AW'(ptr_q);
          wd = rd0_q;
        end else begin
          state_d = alf_pkg::ST_LVL;
        end
      end
      alf_pkg::ST_LVL: begin
        state_d = (half_q == '0) ? alf_pkg::ST_BASERD : alf_pkg::ST_BLK;
      end
      alf_pkg::ST_BLK:   state_d = alf_pkg::ST_SUMRD;
      alf_pkg::ST_SUMRD: begin
        re      = 1'b1;
        ra0     = AW'({i_q, 1'b0});
        ra1     = AW'({i_q, 1'b1});
        state_d = alf_pkg::ST_SUMMUL;
      end
      alf_pkg::ST_SUMMUL: state_d = alf_pkg::ST_SUMACC;
      alf_pkg::ST_SUMACC: state_d = (ip1 == e_q) ? alf_pkg::ST_FIT : alf_pkg::ST_SUMRD;
      alf_pkg::ST_FIT: begin
        fit_start = 1'b1;
        state_d   = alf_pkg::ST_FITW;
      end
      alf_pkg::ST_FITW: begin
        if (fit_done) state_d = alf_pkg::ST_PARAM;
      end
      alf_pkg::ST_PARAM: begin
        emit     = 1'b1;
        e_kind   = alf_pkg::KIND_PARAM;
        e_pos    = blk_q;
        e_ratio  = fit_rsp.ratio;
        e_offset = fit_rsp.offset;
        state_d  = alf_pkg::ST_RESRD;
      end
      alf_pkg::ST_RESRD: begin
        re      = 1'b1;
        ra0     = AW'({i_q, 1'b0});
        ra1     = AW'({i_q, 1'b1});
        state_d = alf_pkg::ST_RESMUL;
      end
      alf_pkg::ST_RESMUL: state_d = alf_pkg::ST_RESOUT;
      alf_pkg::ST_RESOUT: begin
        emit    = 1'b1;
        e_kind  = alf_pkg::KIND_RESIDUAL;
        e_pos   = POS_W'(i_q);
        e_value = dres;
        we      = 1'b1;
        wa      = i_q;
        wd      = low;
        if (ip1 != e_q)                     state_d = alf_pkg::ST_RESRD;
        else if (e_q == (AW+1)'(half_q))    state_d = alf_pkg::ST_LVL;
        else                                state_d = alf_pkg::ST_BLK;
      end
      alf_pkg::ST_BASERD: begin
        re      = 1'b1;
        ra0     = '0;
        state_d = alf_pkg::ST_BASE;
      end
      alf_pkg::ST_BASE: begin
        emit    = 1'b1;
        e_kind  = alf_pkg::KIND_BASE;
        e_value = rd0_q;
        e_last  = 1'b1;
        state_d = alf_pkg::ST_LOAD;
      end
      default: state_d = alf_pkg::ST_LOAD;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= alf_pkg::ST_LOAD;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= emit;
      if (accept) begin
        if (int'(cnt_q) < int'(MAX_LEN)) cnt_q <= cnt_q + CW'(1);
        else                             ovf_q <= 1'b1;
      end
      if (state_q == alf_pkg::ST_BASE) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  // sample memory
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) begin
      rd0_q <= mem[ra0];
      rd1_q <= mem[ra1];
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      alf_pkg::ST_PADRD: begin
        plen_q <= plen_c;
        ptr_q  <= (AW+1)'(cnt_q);
      end
      alf_pkg::ST_PADWR: begin
        if (ptr_q < plen_q) begin
          ptr_q <= ptr_q + (AW+1)'(1);
        end else begin
          half_q <= AW'(plen_q >> 1);
          lvl_q  <= '0;
        end
      end
      alf_pkg::ST_LVL: begin
        s_q   <= '0;
        blk_q <= '0;
      end
      alf_pkg::ST_BLK: begin
        n_q   <= n_c;
        e_q   <= (AW+1)'(s_q) + (AW+1)'(n_c);
        i_q   <= s_q;
        sa_q  <= '0;
        sb_q  <= '0;
        saa_q <= '0;
        sab_q <= '0;
      end
      alf_pkg::ST_SUMMUL: begin
        aa_q <= $signed(rd0_q) * $signed(rd0_q);
        ab_q <= $signed(rd0_q) * $signed(rd1_q);
        sa_q <= sa_q + SUM_W'($signed(rd0_q));
        sb_q <= sb_q + SUM_W'($signed(rd1_q));
      end
      alf_pkg::ST_SUMACC: begin
        saa_q <= saa_q + SQ_W'(aa_q);
        sab_q <= sab_q + SQ_W'(ab_q);
        if (ip1 != e_q) i_q <= AW'(ip1);
      end
      alf_pkg::ST_PARAM: i_q <= s_q;
      alf_pkg::ST_RESMUL: begin
        prod_q <= PM_W'(amag) * PM_W'(rmag);
        pneg_q <= rd0_q[SMP_W-1] ^ fit_rsp.ratio[RATIO_W-1];
      end
      alf_pkg::ST_RESOUT: begin
        if (ip1 != e_q) begin
          i_q <= AW'(ip1);
        end else if (e_q == (AW+1)'(half_q)) begin
          half_q <= half_q >> 1;
          lvl_q  <= lvl_q + LEVEL_W'(1);
        end else begin
          s_q   <= AW'(e_q);
          blk_q <= blk_q + POS_W'(1);
        end
      end
      default: ;
    endcase
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q   <= e_kind;
      level_q  <= lvl_q;
      pos_q    <= e_pos;
      value_q  <= e_value;
      ratio_q  <= e_ratio;
      offset_q <= e_offset;
      length_q <= alf_pkg::LEN_W'(cnt_q);
      ovfo_q   <= ovf_q;
      last_q   <= e_last;
    end
  end

  assign result_strobe_o = strobe_q;
  assign kind_o          = kind_q;
  assign level_o         = level_q;
  assign position_o      = pos_q;
  assign value_o         = value_q;
  assign ratio_o         = ratio_q;
  assign offset_o        = offset_q;
  assign length_o        = length_q;
  assign overflowed_o    = ovfo_q;
  assign last_result_o   = last_q;

endmodule

FILE: hdl/alf_fit.sv
module alf_fit #(
  parameter int unsigned FRAC_BITS = alf_pkg::DEF_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  alf_pkg::fit_req_t req_i,
  output logic              done_o,
  output alf_pkg::fit_rsp_t rsp_o
);

  localparam int unsigned MC_W    = alf_pkg::MC_W;
  localparam int unsigned SUM_W   = alf_pkg::SUM_W;
  localparam int unsigned PR_W    = alf_pkg::PR_W;
  localparam int unsigned Y_W     = alf_pkg::Y_W;
  localparam int unsigned QT_W    = alf_pkg::QT_W;
  localparam int unsigned DV_W    = alf_pkg::DV_W;
  localparam int unsigned CNT_W   = alf_pkg::CNT_W;
  localparam int unsigned RATIO_W = alf_pkg::RATIO_W;
  localparam int unsigned SMP_W   = alf_pkg::SMP_W;

  alf_pkg::fit_state_e state_q, state_d;
  alf_pkg::fit_op_e    op_q, op_d;

  // serial multiplier
  logic [PR_W-1:0]  mc_q, acc_q;
  logic [SUM_W-1:0] mp_q;
  logic             mneg_q;
  logic [CNT_W-1:0] cnt_q;
  logic signed [PR_W-1:0] p_q, t1_q, x_q;
  logic signed [MC_W-1:0] nn_q, dd_q;
  logic [Y_W-1:0]   y_q;
  // divider
  logic [DV_W-1:0]  r_q, dv_q;
  logic [QT_W-1:0]  q_q;
  logic             xneg_q, divrat_q;
  logic signed [RATIO_W-1:0] ratio_q;
  logic [SMP_W-1:0] offset_q;

  logic signed [MC_W-1:0]  mcand;
  logic signed [SUM_W-1:0] mplier;
  logic [MC_W-1:0]         mc_mag;
  logic [SUM_W-1:0]        mp_mag;
  logic                    dzero, nneg, clamp;
  logic [MC_W-1:0]         nmag;
  logic [PR_W-1:0]         xmag;
  logic                    ge;
  logic [QT_W-1:0]         qres;
  logic signed [RATIO_W-1:0] r8;
  logic signed [PR_W-1:0]  sbx, sa8;

  always_comb begin
    unique case (op_q)
      alf_pkg::OP_NSAB: begin mcand = MC_W'(req_i.sab); mplier = SUM_W'(req_i.n); end
      alf_pkg::OP_SASB: begin mcand = MC_W'(req_i.sa);  mplier = req_i.sb;        end
      alf_pkg::OP_NSAA: begin mcand = MC_W'(req_i.saa); mplier = SUM_W'(req_i.n); end
      alf_pkg::OP_SASA: begin mcand = MC_W'(req_i.sa);  mplier = req_i.sa;        end
      alf_pkg::OP_SBD:  begin mcand = dd_q;             mplier = req_i.sb;        end
      alf_pkg::OP_NSA:  begin mcand = nn_q;             mplier = req_i.sa;        end
      alf_pkg::OP_ND:   begin mcand = dd_q;             mplier = SUM_W'(req_i.n); end
      default:          begin mcand = '0;               mplier = '0;              end
    endcase
    mc_mag = mcand[MC_W-1] ? MC_W'(-mcand) : MC_W'(mcand);
    mp_mag = mplier[SUM_W-1] ? SUM_W'(-mplier) : SUM_W'(mplier);
    dzero  = (dd_q == '0);
    nneg   = nn_q[MC_W-1];
    nmag   = nneg ? MC_W'(-nn_q) : MC_W'(nn_q);
    clamp  = {3'b000, nmag} > {dd_q, 3'b000};
    xmag   = x_q[PR_W-1] ? PR_W'(-x_q) : PR_W'(x_q);
    ge     = (r_q >= dv_q);
    qres   = xneg_q ? QT_W'(-q_q) : q_q;
    r8     = RATIO_W'(1) << (FRAC_BITS + 3);
    sbx    = PR_W'(req_i.sb);
    sa8    = PR_W'(req_i.sa) <<< 3;
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    done_o  = 1'b0;
    unique case (state_q)
      alf_pkg::FS_IDLE: begin
        if (start_i) begin
          state_d = alf_pkg::FS_MLOAD;
          op_d    = alf_pkg::OP_NSAB;
        end
      end
      alf_pkg::FS_MLOAD: state_d = alf_pkg::FS_MRUN;
      alf_pkg::FS_MRUN: begin
        if (cnt_q == CNT_W'(SUM_W - 1)) state_d = alf_pkg::FS_MFIN;
      end
      alf_pkg::FS_MFIN: state_d = alf_pkg::FS_MSTORE;
      alf_pkg::FS_MSTORE: begin
        unique case (op_q)
          alf_pkg::OP_NSAB: begin op_d = alf_pkg::OP_SASB; state_d = alf_pkg::FS_MLOAD; end
          alf_pkg::OP_SASB: begin op_d = alf_pkg::OP_NSAA; state_d = alf_pkg::FS_MLOAD; end
          alf_pkg::OP_NSAA: begin op_d = alf_pkg::OP_SASA; state_d = alf_pkg::FS_MLOAD; end
          alf_pkg::OP_SASA: state_d = alf_pkg::FS_DEC;
          alf_pkg::OP_SBD:  begin op_d = alf_pkg::OP_NSA; state_d = alf_pkg::FS_MLOAD; end
          alf_pkg::OP_NSA:  begin op_d = alf_pkg::OP_ND;  state_d = alf_pkg::FS_MLOAD; end
          alf_pkg::OP_ND:   state_d = alf_pkg::FS_DLOAD;
          default:          state_d = alf_pkg::FS_IDLE;
        endcase
      end
      alf_pkg::FS_DEC:   state_d = alf_pkg::FS_DLOAD;
      alf_pkg::FS_DLOAD: state_d = alf_pkg::FS_DRUN;
      alf_pkg::FS_DRUN: begin
        if (cnt_q == CNT_W'(QT_W - 1)) state_d = alf_pkg::FS_DFIN;
      end
      alf_pkg::FS_DFIN: begin
        if (divrat_q) begin
          op_d    = alf_pkg::OP_SBD;
          state_d = alf_pkg::FS_MLOAD;
        end else begin
          done_o  = 1'b1;
          state_d = alf_pkg::FS_IDLE;
        end
      end
      default: state_d = alf_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alf_pkg::FS_IDLE;
      op_q    <= alf_pkg::OP_NSAB;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      alf_pkg::FS_MLOAD: begin
        mc_q   <= PR_W'(mc_mag);
        mp_q   <= mp_mag;
        acc_q  <= '0;
        mneg_q <= mcand[MC_W-1] ^ mplier[SUM_W-1];
        cnt_q  <= '0;
      end
      alf_pkg::FS_MRUN: begin
        if (mp_q[0]) acc_q <= acc_q + mc_q;
        mc_q  <= mc_q << 1;
        mp_q  <= mp_q >> 1;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      alf_pkg::FS_MFIN: p_q <= mneg_q ? -$signed(acc_q) : $signed(acc_q);
      alf_pkg::FS_MSTORE: begin
        unique case (op_q)
          alf_pkg::OP_SASB: nn_q <= MC_W'(t1_q - p_q);
          alf_pkg::OP_SASA: dd_q <= MC_W'(t1_q - p_q);
          alf_pkg::OP_NSA:  x_q  <= t1_q - p_q;
          alf_pkg::OP_ND:   y_q  <= Y_W'(p_q);
          default:          t1_q <= p_q;
        endcase
      end
      alf_pkg::FS_DEC: begin
        // zero spread: flat fit; steep fit: slope held at +-8
        if (dzero) begin
          ratio_q  <= '0;
          x_q      <= sbx;
          y_q      <= Y_W'(req_i.n);
          divrat_q <= 1'b0;
        end else if (clamp) begin
          ratio_q  <= nneg ? -r8 : r8;
          x_q      <= nneg ? (sbx + sa8) : (sbx - sa8);
          y_q      <= Y_W'(req_i.n);
          divrat_q <= 1'b0;
        end else begin
          x_q      <= PR_W'(nn_q) <<< FRAC_BITS;
          y_q      <= Y_W'(dd_q);
          divrat_q <= 1'b1;
        end
      end
      alf_pkg::FS_DLOAD: begin
        xneg_q <= x_q[PR_W-1];
        r_q    <= (DV_W'(xmag) << 1) + DV_W'(y_q);
        dv_q   <= DV_W'(y_q) << QT_W;
        q_q    <= '0;
        cnt_q  <= '0;
      end
      alf_pkg::FS_DRUN: begin
        if (ge) r_q <= r_q - dv_q;
        q_q   <= {q_q[QT_W-2:0], ge};
        dv_q  <= dv_q >> 1;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      alf_pkg::FS_DFIN: begin
        // ratio division is followed by the offset division
        if (divrat_q) begin
          ratio_q  <= qres[RATIO_W-1:0];
          divrat_q <= 1'b0;
        end else begin
          offset_q <= qres[SMP_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.ratio  = ratio_q;
  assign rsp_o.offset = offset_q;

endmodule
